FILE: rtl/obstacle_avoid_sequencer_macros.svh
// Assertion macros for the obstacle avoidance sequencer.
`ifndef OBSTACLE_AVOID_SEQUENCER_MACROS_SVH
`define OBSTACLE_AVOID_SEQUENCER_MACROS_SVH
`ifndef ASSERT_OFF
`define OAS_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define OAS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define OAS_ASSERT(lbl, clk, rstn, prop, msg)
`define OAS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

FILE: rtl/oas_pkg.sv
`default_nettype none
package oas_pkg;

	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 3;
	localparam int WAIT_W = 16;
	localparam int SPEED_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_WARN_DISTANCE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CRUISE_SPEED = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_WAIT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LEFT_WAIT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_WAIT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_WAIT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_TURN_WAIT = 3'd6;

	localparam logic [WAIT_W-1:0] RST_WARN_DISTANCE = 16'd30;
	localparam logic [SPEED_W-1:0] RST_CRUISE_SPEED = 8'd0;
	localparam logic [WAIT_W-1:0] RST_SETTLE_WAIT = 16'd100;
	localparam logic [WAIT_W-1:0] RST_LEFT_WAIT = 16'd500;
	localparam logic [WAIT_W-1:0] RST_RIGHT_WAIT = 16'd1000;
	localparam logic [WAIT_W-1:0] RST_CENTER_WAIT = 16'd500;
	localparam logic [WAIT_W-1:0] RST_TURN_WAIT = 16'd600;

	localparam logic [2:0] PH_CRUISE = 3'd0;
	localparam logic [2:0] PH_SETTLE = 3'd1;
	localparam logic [2:0] PH_LEFT = 3'd2;
	localparam logic [2:0] PH_RIGHT = 3'd3;
	localparam logic [2:0] PH_CENTER = 3'd4;
	localparam logic [2:0] PH_TURN_L = 3'd5;
	localparam logic [2:0] PH_TURN_R = 3'd6;

	localparam logic [2:0] MC_NONE = 3'd0;
	localparam logic [2:0] MC_STOP = 3'd1;
	localparam logic [2:0] MC_ADVANCE = 3'd2;
	localparam logic [2:0] MC_TURN_L = 3'd3;
	localparam logic [2:0] MC_TURN_R = 3'd4;

	localparam logic [1:0] SV_NONE = 2'd0;
	localparam logic [1:0] SV_180 = 2'd1;
	localparam logic [1:0] SV_0 = 2'd2;
	localparam logic [1:0] SV_90 = 2'd3;

	typedef enum logic [6:0] {
		ST_CRUISE = 7'b0000001,
		ST_SETTLE = 7'b0000010,
		ST_LEFT   = 7'b0000100,
		ST_RIGHT  = 7'b0001000,
		ST_CENTER = 7'b0010000,
		ST_TURN_L = 7'b0100000,
		ST_TURN_R = 7'b1000000
	} state_t;

endpackage
`default_nettype wire

FILE: rtl/obstacle_avoid_sequencer.sv
`default_nettype none
`include "obstacle_avoid_sequencer_macros.svh"
// The sequencer takes one poll item per clock and returns one result item per poll: the
// poll is captured in an input register, and a single pass of subtract, compare and phase
// update loads the result register and the sequencer state at the same edge. The sustained
// rate is one item per cycle; only a stall on the result side holds the input back. The
// user must write registers through cfg_we, cfg_index and cfg_data only while no item is
// in flight; the block does not enforce this. Indexes past the last register are ignored.
module obstacle_avoid_sequencer
	import oas_pkg::*;
#(
	parameter int TICK_BITS = 32,
	parameter int RANGE_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_W-1:0]      cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [TICK_BITS-1:0]  now_tick,
	input  wire logic [RANGE_BITS-1:0] range_sample,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [2:0]                 phase,
	output logic [2:0]                 motor_cmd,
	output logic [SPEED_W-1:0]         motor_speed,
	output logic [1:0]                 servo_cmd,
	output logic [RANGE_BITS-1:0]      left_range,
	output logic [RANGE_BITS-1:0]      right_range
);

	localparam int CMP_W = (RANGE_BITS > WAIT_W) ? RANGE_BITS : WAIT_W;

	logic [WAIT_W-1:0] warn_q, settle_q, left_wait_q, right_wait_q, center_q, turn_q;
	logic [SPEED_W-1:0] speed_q;

	logic s1_valid_q;
	logic [TICK_BITS-1:0] tick_s1;
	logic [RANGE_BITS-1:0] range_s1;

	state_t state_q, state_d;
	logic [TICK_BITS-1:0] start_q, start_d;
	logic [RANGE_BITS-1:0] left_q, left_d, right_q, right_d;

	logic out_valid_q;
	logic [2:0] phase_q, phase_d, mcmd_q, mcmd_d;
	logic [SPEED_W-1:0] mspd_q, mspd_d;
	logic [1:0] scmd_q, scmd_d;

	logic out_free, proc;
	logic [TICK_BITS-1:0] elapsed;
	logic [WAIT_W-1:0] wait_sel;
	logic waited;

	assign out_free = !out_valid_q || !out_stall;
	assign proc = s1_valid_q && out_free;
	assign in_stall = s1_valid_q && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warn_q <= RST_WARN_DISTANCE;
			speed_q <= RST_CRUISE_SPEED;
			settle_q <= RST_SETTLE_WAIT;
			left_wait_q <= RST_LEFT_WAIT;
			right_wait_q <= RST_RIGHT_WAIT;
			center_q <= RST_CENTER_WAIT;
			turn_q <= RST_TURN_WAIT;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WARN_DISTANCE: warn_q <= cfg_data;
				CFG_CRUISE_SPEED: speed_q <= cfg_data[SPEED_W-1:0];
				CFG_SETTLE_WAIT: settle_q <= cfg_data;
				CFG_LEFT_WAIT: left_wait_q <= cfg_data;
				CFG_RIGHT_WAIT: right_wait_q <= cfg_data;
				CFG_CENTER_WAIT: center_q <= cfg_data;
				CFG_TURN_WAIT: turn_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (!in_stall) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			tick_s1 <= now_tick;
			range_s1 <= range_sample;
		end
	end

	always_comb begin
		case (state_q)
			ST_SETTLE: wait_sel = settle_q;
			ST_LEFT: wait_sel = left_wait_q;
			ST_RIGHT: wait_sel = right_wait_q;
			ST_CENTER: wait_sel = center_q;
			default: wait_sel = turn_q;
		endcase
		elapsed = tick_s1 - start_q;
		waited = elapsed >= TICK_BITS'(wait_sel);
	end

	always_comb begin
		state_d = state_q;
		start_d = start_q;
		left_d = left_q;
		right_d = right_q;
		mcmd_d = MC_NONE;
		mspd_d = '0;
		scmd_d = SV_NONE;
		case (state_q)
			ST_CRUISE: begin
				if (CMP_W'(range_s1) <= CMP_W'(warn_q)) begin
					mcmd_d = MC_STOP;
					state_d = ST_SETTLE;
					start_d = tick_s1;
				end else begin
					mcmd_d = MC_ADVANCE;
					mspd_d = speed_q;
				end
			end
			ST_SETTLE: begin
				if (waited) begin
					scmd_d = SV_180;
					state_d = ST_LEFT;
					start_d = tick_s1;
				end
			end
			ST_LEFT: begin
				if (waited) begin
					left_d = range_s1;
					scmd_d = SV_0;
					state_d = ST_RIGHT;
					start_d = tick_s1;
				end
			end
			ST_RIGHT: begin
				if (waited) begin
					right_d = range_s1;
					scmd_d = SV_90;
					state_d = ST_CENTER;
					start_d = tick_s1;
				end
			end
			ST_CENTER: begin
				if (waited) begin
					if (right_q > left_q && CMP_W'(right_q) > CMP_W'(warn_q)) begin
						state_d = ST_TURN_R;
						mcmd_d = MC_TURN_R;
					end else begin
						state_d = ST_TURN_L;
						mcmd_d = MC_TURN_L;
					end
					mspd_d = speed_q;
					start_d = tick_s1;
				end
			end
			ST_TURN_L, ST_TURN_R: begin
				if (waited) begin
					mcmd_d = MC_STOP;
					state_d = ST_CRUISE;
				end
			end
			default: state_d = ST_CRUISE;
		endcase
	end

	always_comb begin
		case (state_d)
			ST_SETTLE: phase_d = PH_SETTLE;
			ST_LEFT: phase_d = PH_LEFT;
			ST_RIGHT: phase_d = PH_RIGHT;
			ST_CENTER: phase_d = PH_CENTER;
			ST_TURN_L: phase_d = PH_TURN_L;
			ST_TURN_R: phase_d = PH_TURN_R;
			default: phase_d = PH_CRUISE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CRUISE;
			start_q <= '0;
			left_q <= '0;
			right_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (proc) begin
				state_q <= state_d;
				start_q <= start_d;
				left_q <= left_d;
				right_q <= right_d;
			end
			if (out_free) begin
				out_valid_q <= s1_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			phase_q <= phase_d;
			mcmd_q <= mcmd_d;
			mspd_q <= mspd_d;
			scmd_q <= scmd_d;
		end
	end

	assign out_valid = out_valid_q;
	assign phase = phase_q;
	assign motor_cmd = mcmd_q;
	assign motor_speed = mspd_q;
	assign servo_cmd = scmd_q;
	assign left_range = left_q;
	assign right_range = right_q;

	`OAS_ASSERT_NEXT(a_proc_loads_result, clk, arst_n, proc, out_valid_q, "processed item lost")
	`OAS_ASSERT_NEXT(a_s1_holds, clk, arst_n, in_stall, s1_valid_q && $stable(tick_s1),
		"input register changed while stalled")
	`OAS_ASSERT(a_advance_in_cruise, clk, arst_n,
		!out_valid_q || mcmd_q != MC_ADVANCE || phase_q == PH_CRUISE, "advance outside cruise")
	`OAS_ASSERT(a_turn_right_rule, clk, arst_n,
		!proc || state_d != ST_TURN_R || state_q == ST_TURN_R ||
		(right_q > left_q && CMP_W'(right_q) > CMP_W'(warn_q)),
		"right turn without clear right side")

endmodule
`default_nettype wire
